FILE: sv/rfpm_pkg.sv
// ----------------------------------------------------------------------------
// rfpm_pkg: shared types and constants of the flow packet monitor
// Event and anomaly codes, register indexes, counter widths and helpers.
// ----------------------------------------------------------------------------
package rfpm_pkg;

   // default widths of the sequence number and of the capture time
   localparam int PSN_BITS_DEF  = 24;
   localparam int TIME_BITS_DEF = 48;

   localparam int CNT_W   = 32;   // saturating counters
   localparam int DELAY_W = 31;   // positive part of the signed delay
   localparam int DIN_W   = 32;   // signed delay as captured
   localparam int PRIO_W  = 8;
   localparam int CODE_W  = 3;
   localparam int IDX_W   = 2;    // configuration register index

   localparam logic [PRIO_W-1:0] NO_PRIO = 8'hFF;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_LATENCY_THR = 2'd0;
   localparam logic [IDX_W-1:0] REG_JITTER_THR  = 2'd1;
   localparam logic [IDX_W-1:0] REG_WRAP_THR    = 2'd2;
   localparam logic [IDX_W-1:0] REG_JUMP_THR    = 2'd3;

   // reset values of the configuration registers, cut to width where used
   localparam logic [63:0] LATENCY_THR_RST = 64'd10000;
   localparam logic [63:0] JITTER_THR_RST  = 64'd2000;
   localparam logic [63:0] WRAP_THR_RST    = 64'd8388608;
   localparam logic [63:0] JUMP_THR_RST    = 64'd1024;

   // anomaly kinds, in priority order
   localparam logic [CODE_W-1:0] KIND_NONE    = 3'd0;
   localparam logic [CODE_W-1:0] KIND_SPIKE   = 3'd1;
   localparam logic [CODE_W-1:0] KIND_JITTER  = 3'd2;
   localparam logic [CODE_W-1:0] KIND_PFC     = 3'd3;
   localparam logic [CODE_W-1:0] KIND_PAUSE   = 3'd4;

   // sequence number events
   localparam logic [CODE_W-1:0] EV_FIRST     = 3'd0;
   localparam logic [CODE_W-1:0] EV_QP_RESET  = 3'd1;
   localparam logic [CODE_W-1:0] EV_WRAP      = 3'd2;
   localparam logic [CODE_W-1:0] EV_RETRANS   = 3'd3;
   localparam logic [CODE_W-1:0] EV_IN_ORDER  = 3'd4;
   localparam logic [CODE_W-1:0] EV_SMALL_GAP = 3'd5;
   localparam logic [CODE_W-1:0] EV_LARGE_GAP = 3'd6;
   localparam logic [CODE_W-1:0] EV_OTHER     = 3'd7;

   // control of the input stage as seen by the evaluation stage
   typedef struct packed {
      logic valid;   // a beat waits in the input stage
      logic first;   // first beat of the flow since reset
   } stage_ctl_type;

   // per-beat classification, travels in rsp_tuser
   typedef struct packed {
      logic              fake_delay;
      logic [CODE_W-1:0] psn_event;
      logic [CODE_W-1:0] abnormal_kind;
   } flags_type;

   // add that sticks at all ones
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

endpackage

FILE: sv/rfpm_csr.sv
// ----------------------------------------------------------------------------
// rfpm_csr: threshold registers
// Write-only register file for latency, jitter, wrap and jump thresholds.
// ----------------------------------------------------------------------------
module rfpm_csr #(
   parameter int PSN_BITS  = rfpm_pkg::PSN_BITS_DEF,
   parameter int TIME_BITS = rfpm_pkg::TIME_BITS_DEF,
   parameter int CSR_W     = TIME_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [rfpm_pkg::IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]            csr_wdata,
   output logic [TIME_BITS-1:0]        latency_thr,
   output logic [TIME_BITS:0]          jitter_thr,
   output logic [PSN_BITS-1:0]         wrap_thr,
   output logic [PSN_BITS-1:0]         jump_thr
);

   logic [TIME_BITS-1:0] latency_thr_ff;
   logic [TIME_BITS:0]   jitter_thr_ff;
   logic [PSN_BITS-1:0]  wrap_thr_ff;
   logic [PSN_BITS-1:0]  jump_thr_ff;

   // register writes, each masked to its own width
   always_ff @(posedge clock) begin
      if (reset) begin
         latency_thr_ff <= rfpm_pkg::LATENCY_THR_RST[TIME_BITS-1:0];
         jitter_thr_ff  <= rfpm_pkg::JITTER_THR_RST[TIME_BITS:0];
         wrap_thr_ff    <= rfpm_pkg::WRAP_THR_RST[PSN_BITS-1:0];
         jump_thr_ff    <= rfpm_pkg::JUMP_THR_RST[PSN_BITS-1:0];
      end else if (csr_we) begin
         case (csr_index)
            rfpm_pkg::REG_LATENCY_THR: latency_thr_ff <= csr_wdata[TIME_BITS-1:0];
            rfpm_pkg::REG_JITTER_THR:  jitter_thr_ff  <= csr_wdata[TIME_BITS:0];
            rfpm_pkg::REG_WRAP_THR:    wrap_thr_ff    <= csr_wdata[PSN_BITS-1:0];
            rfpm_pkg::REG_JUMP_THR:    jump_thr_ff    <= csr_wdata[PSN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign latency_thr = latency_thr_ff;
   assign jitter_thr  = jitter_thr_ff;
   assign wrap_thr    = wrap_thr_ff;
   assign jump_thr    = jump_thr_ff;

endmodule

FILE: sv/rfpm_front.sv
// ----------------------------------------------------------------------------
// rfpm_front: input stage
// Registers an accepted beat and its signed interval to the previous capture.
// ----------------------------------------------------------------------------
module rfpm_front #(
   parameter int PSN_BITS  = rfpm_pkg::PSN_BITS_DEF,
   parameter int TIME_BITS = rfpm_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [TIME_BITS-1:0]          timestamp,
   input  logic [rfpm_pkg::DIN_W-1:0]    delay,
   input  logic [PSN_BITS-1:0]           psn,
   input  logic                          pfc_flag,
   input  logic [rfpm_pkg::PRIO_W-1:0]   pfc_prio,
   input  logic                          pause_flag,
   input  logic                          take,
   output rfpm_pkg::stage_ctl_type       ctl,
   output logic [TIME_BITS:0]            s_interval,
   output logic [rfpm_pkg::DIN_W-1:0]    s_delay,
   output logic [PSN_BITS-1:0]           s_psn,
   output logic                          s_pfc_flag,
   output logic [rfpm_pkg::PRIO_W-1:0]   s_pfc_prio,
   output logic                          s_pause_flag
);

   logic                        valid_ff, valid_in;
   logic                        first_ff;
   logic                        seen_ff;
   logic [TIME_BITS-1:0]        prev_time_ff;
   logic [TIME_BITS:0]          interval_ff, interval_in;
   logic [rfpm_pkg::DIN_W-1:0]  delay_ff;
   logic [PSN_BITS-1:0]         psn_ff;
   logic                        pfc_flag_ff;
   logic [rfpm_pkg::PRIO_W-1:0] pfc_prio_ff;
   logic                        pause_flag_ff;
   logic                        accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = accept ? 1'b1 : (take ? 1'b0 : valid_ff);
   end

   // interval is zero on the first beat and while the last capture time is zero
   always_comb begin
      if (seen_ff && (prev_time_ff != '0)) begin
         interval_in = {1'b0, timestamp} - {1'b0, prev_time_ff};
      end else begin
         interval_in = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         first_ff     <= 1'b0;
         seen_ff      <= 1'b0;
         prev_time_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            first_ff     <= !seen_ff;
            seen_ff      <= 1'b1;
            prev_time_ff <= timestamp;
         end
      end
   end

   // beat payload
   always_ff @(posedge clock) begin
      if (accept) begin
         interval_ff   <= interval_in;
         delay_ff      <= delay;
         psn_ff        <= psn;
         pfc_flag_ff   <= pfc_flag;
         pfc_prio_ff   <= pfc_prio;
         pause_flag_ff <= pause_flag;
      end
   end

   assign ctl.valid    = valid_ff;
   assign ctl.first    = first_ff;
   assign s_interval   = interval_ff;
   assign s_delay      = delay_ff;
   assign s_psn        = psn_ff;
   assign s_pfc_flag   = pfc_flag_ff;
   assign s_pfc_prio   = pfc_prio_ff;
   assign s_pause_flag = pause_flag_ff;

endmodule

FILE: sv/rfpm_eval.sv
// ----------------------------------------------------------------------------
// rfpm_eval: flow state and result stage
// Jitter, delay extremes, PSN classification, anomaly flags and counters,
// with the result held in the output register.
// ----------------------------------------------------------------------------
module rfpm_eval #(
   parameter int PSN_BITS  = rfpm_pkg::PSN_BITS_DEF,
   parameter int TIME_BITS = rfpm_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rfpm_pkg::stage_ctl_type       ctl,
   input  logic [TIME_BITS:0]            s_interval,
   input  logic [rfpm_pkg::DIN_W-1:0]    s_delay,
   input  logic [PSN_BITS-1:0]           s_psn,
   input  logic                          s_pfc_flag,
   input  logic [rfpm_pkg::PRIO_W-1:0]   s_pfc_prio,
   input  logic                          s_pause_flag,
   input  logic [TIME_BITS-1:0]          latency_thr,
   input  logic [TIME_BITS:0]            jitter_thr,
   input  logic [PSN_BITS-1:0]           wrap_thr,
   input  logic [PSN_BITS-1:0]           jump_thr,
   output logic                          take,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [TIME_BITS:0]            interval,
   output logic [TIME_BITS:0]            jitter,
   output rfpm_pkg::flags_type           flags,
   output logic [PSN_BITS-1:0]           lost_added,
   output logic [rfpm_pkg::CNT_W-1:0]    retrans_total,
   output logic [rfpm_pkg::CNT_W-1:0]    lost_total,
   output logic [rfpm_pkg::DELAY_W-1:0]  delay_max,
   output logic [rfpm_pkg::DELAY_W-1:0]  delay_min,
   output logic [TIME_BITS:0]            jitter_max,
   output logic [rfpm_pkg::CNT_W-1:0]    abnormal_total
);

   localparam int IVL_W = TIME_BITS + 1;

   // flow state
   logic [IVL_W-1:0]              prev_ivl_ff;
   logic [PSN_BITS-1:0]           base_ff, base_in;
   logic [PSN_BITS-1:0]           step_ff, step_in;
   logic                          known_ff, known_in;
   logic [rfpm_pkg::CNT_W-1:0]    retrans_ff, retrans_in;
   logic [rfpm_pkg::CNT_W-1:0]    lost_ff, lost_in;
   logic [rfpm_pkg::DELAY_W-1:0]  dmax_ff, dmax_in;
   logic [rfpm_pkg::DELAY_W-1:0]  dmin_ff, dmin_in;
   logic [IVL_W-1:0]              jmax_ff, jmax_in;
   logic [rfpm_pkg::CNT_W-1:0]    abn_ff, abn_in;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic [IVL_W-1:0]              out_ivl_ff;
   logic [IVL_W-1:0]              out_jit_ff;
   rfpm_pkg::flags_type           out_flags_ff;
   logic [PSN_BITS-1:0]           out_lost_add_ff;

   // per-beat values
   logic [IVL_W:0]                jdiff;
   logic [IVL_W-1:0]              jit;
   logic [rfpm_pkg::DELAY_W-1:0]  dpos;
   logic                          dvalid;
   logic [PSN_BITS-1:0]           back_dist;
   logic [PSN_BITS-1:0]           fwd_dist;
   logic [PSN_BITS-1:0]           expected;
   logic [PSN_BITS-1:0]           jump;
   logic [PSN_BITS-1:0]           lost_add;
   logic [rfpm_pkg::CODE_W-1:0]   event_code;
   logic [rfpm_pkg::CODE_W-1:0]   kind;
   logic                          fake;

   assign take = ctl.valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      out_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // jitter against the previous interval, none on the first beat
   always_comb begin
      jdiff = {s_interval[IVL_W-1], s_interval} - {prev_ivl_ff[IVL_W-1], prev_ivl_ff};
      if (ctl.first) begin
         jit = '0;
      end else if (jdiff[IVL_W]) begin
         jit = IVL_W'(-jdiff);
      end else begin
         jit = jdiff[IVL_W-1:0];
      end
      jmax_in = (jit > jmax_ff) ? jit : jmax_ff;
   end

   // delay extremes over positive delays only
   always_comb begin
      dpos    = s_delay[rfpm_pkg::DELAY_W-1:0];
      dvalid  = !s_delay[rfpm_pkg::DIN_W-1] && (dpos != '0);
      dmax_in = (dvalid && (dpos > dmax_ff)) ? dpos : dmax_ff;
      dmin_in = (dvalid && ((dmin_ff == '0) || (dpos < dmin_ff))) ? dpos : dmin_ff;
   end

   // sequence number classification
   always_comb begin
      back_dist  = base_ff - s_psn;
      fwd_dist   = s_psn - base_ff;
      expected   = base_ff + step_ff;
      jump       = s_psn - expected;
      base_in    = base_ff;
      step_in    = step_ff;
      known_in   = known_ff;
      retrans_in = retrans_ff;
      lost_in    = lost_ff;
      lost_add   = '0;
      fake       = 1'b0;
      event_code = rfpm_pkg::EV_FIRST;
      if (ctl.first) begin
         base_in  = s_psn;
         step_in  = PSN_BITS'(1);
         known_in = 1'b0;
      end else if (s_psn < base_ff) begin
         // backward: reset of the queue pair or a plain wrap, both rebase
         fake     = 1'b1;
         base_in  = s_psn;
         step_in  = PSN_BITS'(1);
         known_in = 1'b0;
         if (back_dist > wrap_thr) begin
            event_code = rfpm_pkg::EV_QP_RESET;
            retrans_in = '0;
            lost_in    = '0;
         end else begin
            event_code = rfpm_pkg::EV_WRAP;
         end
      end else if (s_psn == base_ff) begin
         event_code = rfpm_pkg::EV_RETRANS;
         fake       = 1'b1;
         retrans_in = rfpm_pkg::sat_add(retrans_ff, rfpm_pkg::CNT_W'(1));
      end else begin
         base_in = s_psn;
         if (!known_ff) begin
            // the first forward step is learned and is in order by definition
            step_in    = fwd_dist;
            known_in   = 1'b1;
            event_code = rfpm_pkg::EV_IN_ORDER;
         end else if (s_psn == expected) begin
            event_code = rfpm_pkg::EV_IN_ORDER;
         end else if (s_psn > expected) begin
            fake     = 1'b1;
            lost_add = jump;
            event_code = (jump > jump_thr) ? rfpm_pkg::EV_LARGE_GAP
                                           : rfpm_pkg::EV_SMALL_GAP;
         end else begin
            fake       = 1'b1;
            event_code = rfpm_pkg::EV_OTHER;
         end
         lost_in = rfpm_pkg::sat_add(lost_ff, rfpm_pkg::CNT_W'(lost_add));
      end
   end

   // anomaly kind in priority order
   always_comb begin
      if (!s_interval[IVL_W-1] && (s_interval[TIME_BITS-1:0] > latency_thr)) begin
         kind = rfpm_pkg::KIND_SPIKE;
      end else if (jit > jitter_thr) begin
         kind = rfpm_pkg::KIND_JITTER;
      end else if (s_pfc_flag && (s_pfc_prio != rfpm_pkg::NO_PRIO)) begin
         kind = rfpm_pkg::KIND_PFC;
      end else if (s_pause_flag && !s_pfc_flag) begin
         kind = rfpm_pkg::KIND_PAUSE;
      end else begin
         kind = rfpm_pkg::KIND_NONE;
      end
      abn_in = (kind != rfpm_pkg::KIND_NONE) ?
               rfpm_pkg::sat_add(abn_ff, rfpm_pkg::CNT_W'(1)) : abn_ff;
   end

   // flow state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_ivl_ff  <= '0;
         base_ff      <= '0;
         step_ff      <= PSN_BITS'(1);
         known_ff     <= 1'b0;
         retrans_ff   <= '0;
         lost_ff      <= '0;
         dmax_ff      <= '0;
         dmin_ff      <= '0;
         jmax_ff      <= '0;
         abn_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            prev_ivl_ff <= s_interval;
            base_ff     <= base_in;
            step_ff     <= step_in;
            known_ff    <= known_in;
            retrans_ff  <= retrans_in;
            lost_ff     <= lost_in;
            dmax_ff     <= dmax_in;
            dmin_ff     <= dmin_in;
            jmax_ff     <= jmax_in;
            abn_ff      <= abn_in;
         end
      end
   end

   // per-beat result payload
   always_ff @(posedge clock) begin
      if (take) begin
         out_ivl_ff                 <= s_interval;
         out_jit_ff                 <= jit;
         out_flags_ff.abnormal_kind <= kind;
         out_flags_ff.psn_event     <= event_code;
         out_flags_ff.fake_delay    <= fake;
         out_lost_add_ff            <= lost_add;
      end
   end

   assign rsp_tvalid     = out_valid_ff;
   assign interval       = out_ivl_ff;
   assign jitter         = out_jit_ff;
   assign flags          = out_flags_ff;
   assign lost_added     = out_lost_add_ff;
   // running totals stay put until the next beat is taken
   assign retrans_total  = retrans_ff;
   assign lost_total     = lost_ff;
   assign delay_max      = dmax_ff;
   assign delay_min      = dmin_ff;
   assign jitter_max     = jmax_ff;
   assign abnormal_total = abn_ff;

endmodule

FILE: sv/rdma_flow_packet_monitor_unit.sv
// ----------------------------------------------------------------------------
// rdma_flow_packet_monitor_unit: per queue-pair packet monitor
// Interval and jitter, delay extremes, PSN event classification, anomaly
// flags and saturating counters for one captured packet per beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             contents
//  req_     in   req_tvalid/tready     captured packet: time, delay, PSN, PFC/pause
//  rsp_     out  rsp_tvalid/tready     interval, jitter, event codes, totals
//  csr_     in   csr_we                threshold register writes, no read-back
//
//  One beat per cycle sustained while rsp_ is not stalled; a beat passes from
//  req_ to rsp_ through the input register, then the result register.
//  Reset is synchronous; thresholds return to defaults and all flow state clears.
//  A stalled rsp_ holds its beat; the input stage still takes one more beat.
// ----------------------------------------------------------------------------
module rdma_flow_packet_monitor_unit #(
   parameter int PSN_BITS  = rfpm_pkg::PSN_BITS_DEF,
   parameter int TIME_BITS = rfpm_pkg::TIME_BITS_DEF,
   parameter int CSR_W     = (TIME_BITS + 1 > PSN_BITS) ? TIME_BITS + 1 : PSN_BITS,
   parameter int REQ_RAW_W = TIME_BITS + rfpm_pkg::DIN_W + PSN_BITS + rfpm_pkg::PRIO_W,
   parameter int REQ_W     = ((REQ_RAW_W + 7) / 8) * 8,
   parameter int RSP_RAW_W = 3 * (TIME_BITS + 1) + PSN_BITS + 3 * rfpm_pkg::CNT_W
                             + 2 * rfpm_pkg::DELAY_W,
   parameter int RSP_W     = ((RSP_RAW_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // timestamp, delay, psn, pfc_prio (zero padded)
   input  logic [REQ_W-1:0]            req_tdata,
   // pfc_flag, pause_flag
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // interval, jitter, lost_added, retrans_total, lost_total, delay_max,
   // delay_min, jitter_max, abnormal_total (zero padded)
   output logic [RSP_W-1:0]            rsp_tdata,
   // abnormal_kind, psn_event, fake_delay
   output logic [6:0]                  rsp_tuser,
   input  logic                        csr_we,
   input  logic [rfpm_pkg::IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   localparam int IVL_W = TIME_BITS + 1;

   logic [TIME_BITS-1:0]          latency_thr;
   logic [IVL_W-1:0]              jitter_thr;
   logic [PSN_BITS-1:0]           wrap_thr;
   logic [PSN_BITS-1:0]           jump_thr;

   logic [TIME_BITS-1:0]          in_timestamp;
   logic [rfpm_pkg::DIN_W-1:0]    in_delay;
   logic [PSN_BITS-1:0]           in_psn;
   logic [rfpm_pkg::PRIO_W-1:0]   in_pfc_prio;

   rfpm_pkg::stage_ctl_type       ctl;
   logic                          take;
   logic [IVL_W-1:0]              s_interval;
   logic [rfpm_pkg::DIN_W-1:0]    s_delay;
   logic [PSN_BITS-1:0]           s_psn;
   logic                          s_pfc_flag;
   logic [rfpm_pkg::PRIO_W-1:0]   s_pfc_prio;
   logic                          s_pause_flag;

   logic [IVL_W-1:0]              interval;
   logic [IVL_W-1:0]              jitter;
   rfpm_pkg::flags_type           flags;
   logic [PSN_BITS-1:0]           lost_added;
   logic [rfpm_pkg::CNT_W-1:0]    retrans_total;
   logic [rfpm_pkg::CNT_W-1:0]    lost_total;
   logic [rfpm_pkg::DELAY_W-1:0]  delay_max;
   logic [rfpm_pkg::DELAY_W-1:0]  delay_min;
   logic [IVL_W-1:0]              jitter_max;
   logic [rfpm_pkg::CNT_W-1:0]    abnormal_total;

   // unpack the request beat
   assign {in_pfc_prio, in_psn, in_delay, in_timestamp} = req_tdata[REQ_RAW_W-1:0];

   rfpm_csr #(
      .PSN_BITS  (PSN_BITS),
      .TIME_BITS (TIME_BITS),
      .CSR_W     (CSR_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .latency_thr (latency_thr),
      .jitter_thr  (jitter_thr),
      .wrap_thr    (wrap_thr),
      .jump_thr    (jump_thr)
   );

   rfpm_front #(
      .PSN_BITS  (PSN_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .timestamp    (in_timestamp),
      .delay        (in_delay),
      .psn          (in_psn),
      .pfc_flag     (req_tuser[0]),
      .pfc_prio     (in_pfc_prio),
      .pause_flag   (req_tuser[1]),
      .take         (take),
      .ctl          (ctl),
      .s_interval   (s_interval),
      .s_delay      (s_delay),
      .s_psn        (s_psn),
      .s_pfc_flag   (s_pfc_flag),
      .s_pfc_prio   (s_pfc_prio),
      .s_pause_flag (s_pause_flag)
   );

   rfpm_eval #(
      .PSN_BITS  (PSN_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_eval (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .s_interval     (s_interval),
      .s_delay        (s_delay),
      .s_psn          (s_psn),
      .s_pfc_flag     (s_pfc_flag),
      .s_pfc_prio     (s_pfc_prio),
      .s_pause_flag   (s_pause_flag),
      .latency_thr    (latency_thr),
      .jitter_thr     (jitter_thr),
      .wrap_thr       (wrap_thr),
      .jump_thr       (jump_thr),
      .take           (take),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .interval       (interval),
      .jitter         (jitter),
      .flags          (flags),
      .lost_added     (lost_added),
      .retrans_total  (retrans_total),
      .lost_total     (lost_total),
      .delay_max      (delay_max),
      .delay_min      (delay_min),
      .jitter_max     (jitter_max),
      .abnormal_total (abnormal_total)
   );

   // pack the result beat
   assign rsp_tdata = RSP_W'({abnormal_total, jitter_max, delay_min, delay_max,
                              lost_total, retrans_total, lost_added, jitter,
                              interval});
   assign rsp_tuser = flags;

   // first beat of a flow carries no interval, jitter or fake delay
   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (flags.psn_event == rfpm_pkg::EV_FIRST)
      |-> (interval == '0) && (jitter == '0) && !flags.fake_delay)
      else $error("first beat with nonzero interval, jitter or fake delay");

   // only a gap adds lost packets
   a_lost_only_on_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (lost_added != '0)
      |-> (flags.psn_event == rfpm_pkg::EV_SMALL_GAP) ||
          (flags.psn_event == rfpm_pkg::EV_LARGE_GAP))
      else $error("lost packets counted without a gap event");

   // delay extremes stay ordered once a positive delay was seen
   a_delay_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (delay_min != '0) |-> (delay_min <= delay_max))
      else $error("smallest delay above largest delay");

   // an in-order beat never reports a fake delay
   a_in_order_true: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (flags.psn_event == rfpm_pkg::EV_IN_ORDER) |-> !flags.fake_delay)
      else $error("in-order beat flagged with fake delay");

endmodule

FILE: sim/rfpm_checker.sv
// ----------------------------------------------------------------------------
// rfpm_checker: result checker of the flow packet monitor
// Watches the threshold writes and both stream channels, keeps its own copy
// of the flow state, predicts one report per packet beat and compares every
// report beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rfpm_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // timestamp, delay, psn, pfc_prio
   input  logic [111:0]                req_tdata,
   // pfc_flag, pause_flag
   input  logic [1:0]                  req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // interval, jitter, lost_added, retrans_total, lost_total, delay_max,
   // delay_min, jitter_max, abnormal_total
   input  logic [335:0]                rsp_tdata,
   // abnormal_kind, psn_event, fake_delay
   input  logic [6:0]                  rsp_tuser,
   input  logic                        csr_we,
   input  logic [rfpm_pkg::IDX_W-1:0]  csr_index,
   input  logic [48:0]                 csr_wdata,
   output int                          mismatch_count,
   output int                          reports_pending
);

   // report fields as packed in rsp_tdata, last field on top
   typedef struct packed {
      logic [31:0] abnormal_total;
      logic [48:0] jitter_max;
      logic [30:0] delay_min;
      logic [30:0] delay_max;
      logic [31:0] lost_total;
      logic [31:0] retrans_total;
      logic [23:0] lost_added;
      logic [48:0] jitter;
      logic [48:0] interval;
   } rsp_fields_type;

   typedef struct packed {
      rsp_fields_type      data;
      rfpm_pkg::flags_type flags;
   } flow_report_type;

   // predictions waiting for their report beat, oldest at the read pointer
   flow_report_type exp_mem [0:7];
   logic [2:0]      exp_wr_ptr;
   logic [2:0]      exp_rd_ptr;
   logic [3:0]      exp_fill;

   // thresholds
   logic [47:0] latency_thr;
   logic [48:0] jitter_thr;
   logic [23:0] wrap_thr;
   logic [23:0] jump_thr;

   // flow state
   logic [1:0]  seen_cnt;
   logic [47:0] last_ts;
   longint      last_ivl;
   logic [23:0] base_psn;
   logic [23:0] step_psn;
   logic        step_set;
   logic [31:0] retrans_cnt;
   logic [31:0] lost_cnt;
   logic [30:0] delay_hi;
   logic [30:0] delay_lo;
   logic [63:0] jitter_hi;
   logic [31:0] abn_cnt;

   // advance the flow state by one packet and return its report
   function automatic flow_report_type predict_packet(input logic [111:0] beat,
                                                      input logic [1:0] marks);
      logic [47:0]  ts;
      logic [31:0]  dly;
      logic [23:0]  psn;
      logic [7:0]   prio;
      logic         pfc;
      logic         pause;
      logic         first;
      longint       t_now;
      longint       t_last;
      longint       t_thr;
      longint       ivl;
      longint       diff;
      logic [63:0]  jit;
      logic [23:0]  next_psn;
      logic [23:0]  gap;
      logic [32:0]  sum;
      flow_report_type r;

      ts    = beat[47:0];
      dly   = beat[79:48];
      psn   = beat[103:80];
      prio  = beat[111:104];
      pfc   = marks[0];
      pause = marks[1];
      r     = '0;

      first = (seen_cnt == 2'd0);
      if (seen_cnt != 2'd2) seen_cnt = seen_cnt + 2'd1;
      if (first) last_ts = ts;

      // interval; a zero previous time gives no interval
      t_now  = longint'(ts);
      t_last = longint'(last_ts);
      if (last_ts != 48'd0) ivl = t_now - t_last;
      else ivl = 0;
      last_ts = ts;

      // only positive delays count toward the extremes
      if (dly != 32'd0 && !dly[31]) begin
         if (dly[30:0] > delay_hi) delay_hi = dly[30:0];
         if (delay_lo == 31'd0 || dly[30:0] < delay_lo) delay_lo = dly[30:0];
      end

      jit = 64'd0;
      if (!first) begin
         diff = ivl - last_ivl;
         if (diff < 0) jit = -diff;
         else jit = diff;
         if (jit > jitter_hi) jitter_hi = jit;
      end
      last_ivl = ivl;

      // sequence number classification
      if (first) begin
         base_psn = psn;
         step_psn = 24'd1;
         step_set = 1'b0;
         r.flags.psn_event = rfpm_pkg::EV_FIRST;
      end else if (psn < base_psn) begin
         r.flags.fake_delay = 1'b1;
         if (base_psn - psn > wrap_thr) begin
            r.flags.psn_event = rfpm_pkg::EV_QP_RESET;
            retrans_cnt = 32'd0;
            lost_cnt    = 32'd0;
         end else begin
            r.flags.psn_event = rfpm_pkg::EV_WRAP;
         end
         base_psn = psn;
         step_psn = 24'd1;
         step_set = 1'b0;
      end else if (psn == base_psn) begin
         r.flags.psn_event  = rfpm_pkg::EV_RETRANS;
         r.flags.fake_delay = 1'b1;
         if (retrans_cnt != 32'hFFFF_FFFF) retrans_cnt = retrans_cnt + 32'd1;
      end else begin
         if (!step_set) begin
            step_psn = psn - base_psn;
            step_set = 1'b1;
         end
         next_psn = base_psn + step_psn;
         gap = (psn > next_psn) ? psn - next_psn : 24'd0;
         if (psn == next_psn) begin
            r.flags.psn_event = rfpm_pkg::EV_IN_ORDER;
         end else if (gap > jump_thr) begin
            r.flags.psn_event  = rfpm_pkg::EV_LARGE_GAP;
            r.flags.fake_delay = 1'b1;
            r.data.lost_added  = gap;
         end else if (gap != 24'd0) begin
            r.flags.psn_event  = rfpm_pkg::EV_SMALL_GAP;
            r.flags.fake_delay = 1'b1;
            r.data.lost_added  = gap;
         end else begin
            r.flags.psn_event  = rfpm_pkg::EV_OTHER;
            r.flags.fake_delay = 1'b1;
         end
         sum = {1'b0, lost_cnt} + 33'(r.data.lost_added);
         lost_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         base_psn = psn;
      end

      // anomaly in priority order
      t_thr = longint'(latency_thr);
      if (ivl > 0 && ivl > t_thr) r.flags.abnormal_kind = rfpm_pkg::KIND_SPIKE;
      else if (jit > 64'(jitter_thr)) r.flags.abnormal_kind = rfpm_pkg::KIND_JITTER;
      else if (pfc && prio != rfpm_pkg::NO_PRIO) r.flags.abnormal_kind = rfpm_pkg::KIND_PFC;
      else if (pause && !pfc) r.flags.abnormal_kind = rfpm_pkg::KIND_PAUSE;
      else r.flags.abnormal_kind = rfpm_pkg::KIND_NONE;
      if (r.flags.abnormal_kind != rfpm_pkg::KIND_NONE && abn_cnt != 32'hFFFF_FFFF)
         abn_cnt = abn_cnt + 32'd1;

      r.data.interval       = ivl[48:0];
      r.data.jitter         = jit[48:0];
      r.data.retrans_total  = retrans_cnt;
      r.data.lost_total     = lost_cnt;
      r.data.delay_max      = delay_hi;
      r.data.delay_min      = delay_lo;
      r.data.jitter_max     = jitter_hi[48:0];
      r.data.abnormal_total = abn_cnt;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
   endtask

   // watch the channels at every rising edge
   always @(posedge clock) begin
      flow_report_type     want;
      rsp_fields_type      got;
      rfpm_pkg::flags_type got_flags;

      if (reset) begin
         latency_thr = rfpm_pkg::LATENCY_THR_RST[47:0];
         jitter_thr  = rfpm_pkg::JITTER_THR_RST[48:0];
         wrap_thr    = rfpm_pkg::WRAP_THR_RST[23:0];
         jump_thr    = rfpm_pkg::JUMP_THR_RST[23:0];
         seen_cnt    = 2'd0;
         last_ts     = 48'd0;
         last_ivl    = 0;
         base_psn    = 24'd0;
         step_psn    = 24'd1;
         step_set    = 1'b0;
         retrans_cnt = 32'd0;
         lost_cnt    = 32'd0;
         delay_hi    = 31'd0;
         delay_lo    = 31'd0;
         jitter_hi   = 64'd0;
         abn_cnt     = 32'd0;
         exp_wr_ptr  = 3'd0;
         exp_rd_ptr  = 3'd0;
         exp_fill    = 4'd0;
         reports_pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rfpm_pkg::REG_LATENCY_THR: latency_thr = csr_wdata[47:0];
               rfpm_pkg::REG_JITTER_THR:  jitter_thr  = csr_wdata[48:0];
               rfpm_pkg::REG_WRAP_THR:    wrap_thr    = csr_wdata[23:0];
               rfpm_pkg::REG_JUMP_THR:    jump_thr    = csr_wdata[23:0];
               default: ;
            endcase
         end

         // report beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (exp_fill == 4'd0) begin
               mismatch_count++;
               $display("%0t: report beat expected none actual 0x%0h",
                        $time, rsp_tdata);
            end else begin
               want       = exp_mem[exp_rd_ptr];
               exp_rd_ptr = exp_rd_ptr + 3'd1;
               exp_fill   = exp_fill - 4'd1;
               got        = rsp_fields_type'(rsp_tdata[328:0]);
               got_flags  = rfpm_pkg::flags_type'(rsp_tuser);
               check_field("interval", 64'(want.data.interval), 64'(got.interval));
               check_field("jitter", 64'(want.data.jitter), 64'(got.jitter));
               check_field("abnormal_kind", 64'(want.flags.abnormal_kind),
                           64'(got_flags.abnormal_kind));
               check_field("psn_event", 64'(want.flags.psn_event),
                           64'(got_flags.psn_event));
               check_field("fake_delay", 64'(want.flags.fake_delay),
                           64'(got_flags.fake_delay));
               check_field("lost_added", 64'(want.data.lost_added),
                           64'(got.lost_added));
               check_field("retrans_total", 64'(want.data.retrans_total),
                           64'(got.retrans_total));
               check_field("lost_total", 64'(want.data.lost_total),
                           64'(got.lost_total));
               check_field("delay_max", 64'(want.data.delay_max), 64'(got.delay_max));
               check_field("delay_min", 64'(want.data.delay_min), 64'(got.delay_min));
               check_field("jitter_max", 64'(want.data.jitter_max),
                           64'(got.jitter_max));
               check_field("abnormal_total", 64'(want.data.abnormal_total),
                           64'(got.abnormal_total));
            end
         end

         // prediction for every accepted packet beat
         if (req_tvalid && req_tready) begin
            if (exp_fill == 4'd8) begin
               mismatch_count++;
               $display("%0t: packets in flight expected at most 8 actual %0d",
                        $time, exp_fill + 4'd1);
            end else begin
               exp_mem[exp_wr_ptr] = predict_packet(req_tdata, req_tuser);
               exp_wr_ptr = exp_wr_ptr + 3'd1;
               exp_fill   = exp_fill + 4'd1;
            end
         end

         reports_pending <= int'(exp_fill);
      end
   end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench of the flow packet monitor
// Drives packet beats under several threshold settings: a directed run over
// every sequence event and anomaly kind, random flows with gaps, losses,
// rewinds and timestamp jumps, and a run that drives the lost counter into
// saturation. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   logic [111:0]               req_tdata   = '0;
   logic [1:0]                 req_tuser   = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   logic [335:0]               rsp_tdata;
   logic [6:0]                 rsp_tuser;
   logic                       csr_we      = 1'b0;
   logic [rfpm_pkg::IDX_W-1:0] csr_index   = '0;
   logic [48:0]                csr_wdata   = '0;
   int                         mismatch_count;
   int                         reports_pending;
   logic                       steady      = 1'b0;   // no idling on either side

   // random flow generator state
   logic [23:0]         gen_psn;
   logic [23:0]         gen_step;
   logic [47:0]         gen_ts;

   rdma_flow_packet_monitor_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rfpm_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // report side stalls at random
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || ($urandom_range(0, 99) >= 20);
   end

   // one packet beat, now and then with a random gap ahead of it unless steady
   task automatic send_packet(input logic [47:0] ts, input logic [31:0] dly,
                              input logic [23:0] psn, input logic pfc,
                              input logic [7:0] prio, input logic pause);
      if (!steady && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 30);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, psn, dly, ts};
      req_tuser  <= {pause, pfc};
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every report has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (reports_pending != 0);
   endtask

   task automatic set_thresholds(input logic [47:0] lat, input logic [48:0] jit,
                                 input logic [23:0] wrap, input logic [23:0] jump);
      csr_we    <= 1'b1;
      csr_index <= rfpm_pkg::REG_LATENCY_THR;
      csr_wdata <= {1'b0, lat};
      @(posedge clock);
      csr_index <= rfpm_pkg::REG_JITTER_THR;
      csr_wdata <= jit;
      @(posedge clock);
      csr_index <= rfpm_pkg::REG_WRAP_THR;
      csr_wdata <= {25'd0, wrap};
      @(posedge clock);
      csr_index <= rfpm_pkg::REG_JUMP_THR;
      csr_wdata <= {25'd0, jump};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly well-formed flow with losses, rewinds and time jumps mixed in
   task automatic random_packet();
      logic [31:0] dly;
      logic [7:0]  prio;
      int          pick;

      pick = $urandom_range(0, 99);
      if (pick < 45) gen_psn = gen_psn + gen_step;
      else if (pick < 55) gen_psn = gen_psn;
      else if (pick < 65) gen_psn = gen_psn + gen_step + 24'($urandom_range(1, 40));
      else if (pick < 72) gen_psn = gen_psn + gen_step + 24'($urandom_range(41, 200000));
      else if (pick < 80) begin
         gen_psn  = gen_psn - 24'($urandom_range(1, 5000));
         gen_step = 24'($urandom_range(1, 4));
      end else if (pick < 85) gen_psn = gen_psn + 24'd1;
      else begin
         gen_psn  = 24'($urandom);
         gen_step = 24'($urandom_range(1, 4));
      end

      pick = $urandom_range(0, 99);
      if (pick < 70) gen_ts = gen_ts + 48'($urandom_range(0, 3000));
      else if (pick < 82) gen_ts = gen_ts + 48'($urandom_range(3001, 40000));
      else if (pick < 90) gen_ts = gen_ts - 48'($urandom_range(0, 5000));
      else if (pick < 97) gen_ts = 48'({$urandom, $urandom});
      else gen_ts = '0;

      pick = $urandom_range(0, 99);
      if (pick < 50) dly = $urandom_range(1, 100000);
      else if (pick < 60) dly = 32'd0;
      else dly = $urandom;

      if ($urandom_range(0, 1) != 0) prio = rfpm_pkg::NO_PRIO;
      else prio = 8'($urandom);

      send_packet(gen_ts, dly, gen_psn, $urandom_range(0, 99) < 20, prio,
                  $urandom_range(0, 99) < 20);
   endtask

   task automatic run_random(input int count);
      repeat (count) random_packet();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed flow under reset thresholds
      send_packet(48'd0,     32'd0,         24'd100,     1'b0, rfpm_pkg::NO_PRIO, 1'b0); // first, zero time
      send_packet(48'd500,   32'h7FFF_FFFF, 24'd101,     1'b0, rfpm_pkg::NO_PRIO, 1'b0); // zero prev time
      send_packet(48'd1000,  32'd1,         24'd102,     1'b0, rfpm_pkg::NO_PRIO, 1'b0); // in order
      send_packet(48'd21000, 32'hFFFF_FFFF, 24'd102,     1'b0, rfpm_pkg::NO_PRIO, 1'b0); // spike, retransmit
      send_packet(48'd800,   32'h8000_0000, 24'd105,     1'b0, rfpm_pkg::NO_PRIO, 1'b0); // time backward, loss
      send_packet(48'd1300,  32'd5,         24'd2106,    1'b0, rfpm_pkg::NO_PRIO, 1'b0); // large jump
      send_packet(48'd1800,  32'd70,        24'd50,      1'b1, 8'd3,              1'b0); // wrap, pfc
      send_packet(48'd2300,  32'd0,         24'd51,      1'b1, rfpm_pkg::NO_PRIO, 1'b1); // pfc without prio
      send_packet(48'd2800,  32'd9,         24'd53,      1'b0, rfpm_pkg::NO_PRIO, 1'b1); // small loss, pause
      send_packet(48'd3300,  32'd2,         24'hFF_FFFF, 1'b0, 8'd0,              1'b0); // large jump
      send_packet(48'd3800,  32'd3,         24'd0,       1'b0, rfpm_pkg::NO_PRIO, 1'b0); // QP reset
      send_packet(48'd4300,  32'd4,         24'd4,       1'b0, rfpm_pkg::NO_PRIO, 1'b0); // step of four
      send_packet(48'd9300,  32'd4,         24'd6,       1'b0, rfpm_pkg::NO_PRIO, 1'b0); // short of expected
      send_packet(48'hFFFF_FFFF_FFFF, 32'd8, 24'd10,     1'b1, 8'hFE,             1'b1); // time at top
      send_packet(48'd0,     32'd8,         24'd14,      1'b0, rfpm_pkg::NO_PRIO, 1'b1); // time to zero
      send_packet(48'd10,    32'd6,         24'hFF_FFF8, 1'b0, rfpm_pkg::NO_PRIO, 1'b0); // large jump
      send_packet(48'd20,    32'd6,         24'hFF_FFF0, 1'b0, rfpm_pkg::NO_PRIO, 1'b0); // wrap
      send_packet(48'd30,    32'd6,         24'hFF_FFF8, 1'b0, rfpm_pkg::NO_PRIO, 1'b0); // step of eight
      send_packet(48'd40,    32'd6,         24'hFF_FFF9, 1'b0, rfpm_pkg::NO_PRIO, 1'b0); // expected wraps

      gen_psn  = 24'hFF_FFF9;
      gen_step = 24'd1;
      gen_ts   = 48'd5000;
      run_random(50);

      // every threshold at zero
      drain();
      set_thresholds(48'd0, 49'd0, 24'd0, 24'd0);
      run_random(50);

      // every threshold at its top but jitter one below it, both sides without idling
      drain();
      steady <= 1'b1;
      set_thresholds(48'hFFFF_FFFF_FFFF, 49'h1_FFFF_FFFF_FFFE, 24'hFF_FFFF, 24'hFF_FFFF);
      run_random(50);
      drain();
      steady <= 1'b0;

      // moderate random thresholds
      set_thresholds(48'($urandom_range(1000, 20000)), 49'($urandom_range(200, 5000)),
                     24'($urandom), 24'($urandom_range(0, 300)));
      run_random(50);

      // wrap, in order, far jump: drives the lost count into saturation
      drain();
      set_thresholds(48'({$urandom, $urandom}), 49'({$urandom, $urandom}),
                     24'hFF_FFFF, 24'd0);
      repeat (260) begin
         gen_ts = gen_ts + 48'($urandom_range(0, 3000));
         send_packet(gen_ts, $urandom, 24'd0, $urandom_range(0, 1) != 0, 8'($urandom),
                     1'b0);
         send_packet(gen_ts + 48'd10, $urandom, 24'd1, 1'b0, rfpm_pkg::NO_PRIO,
                     $urandom_range(0, 1) != 0);
         send_packet(gen_ts + 48'd20, $urandom, 24'hFF_FFFF, 1'b0, rfpm_pkg::NO_PRIO, 1'b0);
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("rdma_flow_packet_monitor_unit regression: pass");
      end else begin
         $display("rdma_flow_packet_monitor_unit regression: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("rdma_flow_packet_monitor_unit regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
sv/rfpm_pkg.sv
sv/rfpm_csr.sv
sv/rfpm_front.sv
sv/rfpm_eval.sv
sv/rdma_flow_packet_monitor_unit.sv
sim/rfpm_checker.sv
sim/tb_top.sv
